// File: design/cca_pkg.sv
// Shared constants, types and helpers for the cave cellular automaton.
`timescale 1ns / 1ps

package cca_pkg;

  // Grid geometry
  localparam int ROWS = 64;
  localparam int COLS = 64;

  // Port field widths
  localparam int ROW_W     = 64;
  localparam int ROW_IDX_W = 6;
  localparam int LIMIT_W   = 4;
  localparam int REG_IDX_W = 8;

  // Row address and row counter widths
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_CW = $clog2(ROWS + 1);

  // Lane split of one row
  localparam int LANE_COLS = 8;
  localparam int N_LANES   = (COLS + LANE_COLS - 1) / LANE_COLS;
  localparam int LANE_SPAN = N_LANES * LANE_COLS;
  localparam int EXT_W     = LANE_SPAN + 2;
  localparam int CNT_W     = 4;

  // Register reset values
  localparam logic [LIMIT_W-1:0] BIRTH_RST = LIMIT_W'(4);
  localparam logic [LIMIT_W-1:0] DEATH_RST = LIMIT_W'(3);
  localparam logic [LIMIT_W-1:0] GENS_RST  = LIMIT_W'(6);

  typedef logic [COLS-1:0]  row_t;
  typedef logic [EXT_W-1:0] ext_row_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BIRTH = 8'd0,
    REG_DEATH = 8'd1,
    REG_GENS  = 8'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] birth_limit;
    logic [LIMIT_W-1:0] death_limit;
    logic [LIMIT_W-1:0] generations;
  } cca_cfg_t;

  // Pad a row with live cells on both sides and above the last lane column.
  function automatic ext_row_t extend_row(input row_t row);
    ext_row_t ext;
    ext = '1;
    ext[COLS:1] = row;
    return ext;
  endfunction

endpackage

// File: design/cca_ifs.sv
// Handshake channels of the cave cellular automaton: rows in, rows out, register writes.
`timescale 1ns / 1ps

interface cca_row_if import cca_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_cells;

  modport source (output valid, output row_cells, input ready);
  modport sink   (input valid, input row_cells, output ready);
endinterface

interface cca_res_if import cca_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [ROW_IDX_W-1:0] row_index;
  logic [ROW_W-1:0]     result_cells;
  logic                 final_row;

  modport source (output valid, output row_index, output result_cells, output final_row,
                  input ready);
  modport sink   (input valid, input row_index, input result_cells, input final_row,
                  output ready);
endinterface

interface cca_cfg_if import cca_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [LIMIT_W-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: design/cca_lane.sv
// One lane: next state of LANE_COLS adjacent cells from a three-row window.
`timescale 1ns / 1ps

module cca_lane import cca_pkg::*; (
  input  logic [LANE_COLS+1:0] above,
  input  logic [LANE_COLS+1:0] mid,
  input  logic [LANE_COLS+1:0] below,
  input  logic [LIMIT_W-1:0]   birth_limit,
  input  logic [LIMIT_W-1:0]   death_limit,
  output logic [LANE_COLS-1:0] next_bits
);

  // Count the eight neighbors of each cell and apply birth/survival
  always_comb begin
    logic [CNT_W-1:0] count;
    for (int i = 0; i < LANE_COLS; i++) begin
      count = CNT_W'(above[i]) + CNT_W'(above[i+1]) + CNT_W'(above[i+2])
            + CNT_W'(mid[i])                        + CNT_W'(mid[i+2])
            + CNT_W'(below[i]) + CNT_W'(below[i+1]) + CNT_W'(below[i+2]);
      if (mid[i+1]) begin
        next_bits[i] = (count >= death_limit);
      end else begin
        next_bits[i] = (count > birth_limit);
      end
    end
  end

endmodule

// File: design/cca_engine.sv
// Grid store, pass sequencer, lane array with merge, and result output register.
`timescale 1ns / 1ps

module cca_engine import cca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cca_cfg_t         cfg_regs,
  cca_row_if.sink          row_in,
  cca_res_if.source        res_out
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_PASS_END,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [ROW_AW-1:0]   load_cnt;
  logic [ROW_CW-1:0]   rd_cnt;
  logic [LIMIT_W-1:0]  gen_cnt;
  logic [ROW_CW-1:0]   emit_rd;
  logic                step_valid;
  logic [ROW_CW-1:0]   step_row;
  logic                data_valid;
  logic [ROW_AW-1:0]   data_row;
  logic                out_valid;
  logic [ROW_AW-1:0]   out_row;
  row_t                out_cells;

  // Two ping-pong banks of the grid
  row_t mem0 [ROWS];
  row_t mem1 [ROWS];
  row_t rdata0;
  row_t rdata1;

  logic              rd_en0, rd_en1;
  logic [ROW_AW-1:0] rd_addr;
  logic              wr_en0, wr_en1;
  logic [ROW_AW-1:0] wr_addr0, wr_addr1;
  row_t              wr_data0;

  // Pass window
  row_t above;
  row_t mid;
  row_t below;
  row_t rdata_src;
  row_t rdata_emit;
  row_t new_row;
  logic [LANE_SPAN-1:0] merged;
  ext_row_t ext_above, ext_mid, ext_below;

  logic src_bank, fin_bank;
  logic load_acc, pass_issue, emit_issue, moving, step_write, is_flush;
  logic [ROW_AW-1:0] step_wr_addr;
  logic [ROW_CW-1:0] step_row_dec;
  logic [LIMIT_W-1:0] gen_cnt_inc;

  assign src_bank   = gen_cnt[0];
  assign fin_bank   = cfg_regs.generations[0];
  assign rdata_src  = src_bank ? rdata1 : rdata0;
  assign rdata_emit = fin_bank ? rdata1 : rdata0;

  // Handshake qualifiers
  assign row_in.ready = (state == ST_LOAD);
  assign load_acc     = row_in.valid && row_in.ready;
  assign moving       = data_valid && (!out_valid || res_out.ready);
  assign pass_issue   = (state == ST_PASS) && (rd_cnt < ROW_CW'(ROWS));
  assign emit_issue   = (state == ST_EMIT) && (emit_rd < ROW_CW'(ROWS))
                        && (!data_valid || moving);

  // Read port steering: one reader at a time
  assign rd_addr = pass_issue ? rd_cnt[ROW_AW-1:0] : emit_rd[ROW_AW-1:0];
  assign rd_en0  = (pass_issue && !src_bank) || (emit_issue && !fin_bank);
  assign rd_en1  = (pass_issue && src_bank) || (emit_issue && fin_bank);

  // Step: row k arrives, row k-1 of the new grid is finished
  assign is_flush     = (step_row == ROW_CW'(ROWS));
  assign below        = is_flush ? '1 : rdata_src;
  assign step_row_dec = step_row - ROW_CW'(1);
  assign step_wr_addr = step_row_dec[ROW_AW-1:0];
  assign step_write   = step_valid && (step_row != '0);

  assign ext_above = extend_row(above);
  assign ext_mid   = extend_row(mid);
  assign ext_below = extend_row(below);

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    cca_lane u_lane (
      .above       (ext_above[l*LANE_COLS +: LANE_COLS+2]),
      .mid         (ext_mid[l*LANE_COLS +: LANE_COLS+2]),
      .below       (ext_below[l*LANE_COLS +: LANE_COLS+2]),
      .birth_limit (cfg_regs.birth_limit),
      .death_limit (cfg_regs.death_limit),
      .next_bits   (merged[l*LANE_COLS +: LANE_COLS])
    );
  end

  // Merge lane results into one row, drop the padding columns
  assign new_row = merged[COLS-1:0];

  // Write port steering: loads go to bank 0, a pass writes the other bank
  always_comb begin
    wr_en0   = 1'b0;
    wr_addr0 = step_wr_addr;
    wr_data0 = new_row;
    if (load_acc) begin
      wr_en0   = 1'b1;
      wr_addr0 = load_cnt;
      wr_data0 = row_in.row_cells[COLS-1:0];
    end else if (step_write && src_bank) begin
      wr_en0 = 1'b1;
    end
  end

  assign wr_en1   = step_write && !src_bank;
  assign wr_addr1 = step_wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem0[wr_addr0] <= wr_data0;
    end
    if (rd_en0) begin
      rdata0 <= mem0[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en1) begin
      mem1[wr_addr1] <= new_row;
    end
    if (rd_en1) begin
      rdata1 <= mem1[rd_addr];
    end
  end

  // Shift the window down one row per step
  always_ff @(posedge clk) begin
    if (step_valid) begin
      if (step_row == '0) begin
        above <= '1;
      end else begin
        above <= mid;
      end
      mid <= below;
    end
  end

  assign gen_cnt_inc = gen_cnt + LIMIT_W'(1);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_cnt   <= '0;
      rd_cnt     <= '0;
      gen_cnt    <= '0;
      emit_rd    <= '0;
      step_valid <= 1'b0;
      data_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (load_cnt == ROW_AW'(ROWS - 1)) begin
              load_cnt <= '0;
              gen_cnt  <= '0;
              rd_cnt   <= '0;
              emit_rd  <= '0;
              if (cfg_regs.generations == '0) begin
                state <= ST_EMIT;
              end else begin
                state <= ST_PASS;
              end
            end else begin
              load_cnt <= load_cnt + ROW_AW'(1);
            end
          end
        end
        ST_PASS: begin
          step_valid <= 1'b1;
          step_row   <= rd_cnt;
          if (pass_issue) begin
            rd_cnt <= rd_cnt + ROW_CW'(1);
          end else begin
            state <= ST_PASS_END;
          end
        end
        ST_PASS_END: begin
          step_valid <= 1'b0;
          gen_cnt    <= gen_cnt_inc;
          rd_cnt     <= '0;
          if (gen_cnt_inc == cfg_regs.generations) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_PASS;
          end
        end
        ST_EMIT: begin
          if (emit_issue) begin
            emit_rd  <= emit_rd + ROW_CW'(1);
            data_row <= emit_rd[ROW_AW-1:0];
          end
          if (emit_rd == ROW_CW'(ROWS) && (!data_valid || moving)) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase

      // Read data waiting for the output register
      if (emit_issue) begin
        data_valid <= 1'b1;
      end else if (moving) begin
        data_valid <= 1'b0;
      end

      // Hold the result until taken
      if (moving) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end

    if (moving) begin
      out_row   <= data_row;
      out_cells <= rdata_emit;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.row_index    = ROW_IDX_W'(out_row);
  assign res_out.result_cells = ROW_W'(out_cells);
  assign res_out.final_row    = (out_row == ROW_AW'(ROWS - 1));

  // The pass tail cycle always carries the bottom flush step
  a_pass_end_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS_END) |-> (step_valid && is_flush))
    else $error("pass ended without flush step");

  // No pass step or pending read data while rows are loading
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (!data_valid && !step_valid))
    else $error("datapath busy during load");

  // Moving the bottom row out ends emission
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (moving && data_row == ROW_AW'(ROWS - 1)) |=> (state == ST_LOAD))
    else $error("emission did not end after bottom row");

endmodule

// File: design/cave_cellular_automaton_top.sv
// Top level of the cave cellular automaton: configuration registers and the grid engine.
`timescale 1ns / 1ps

// Load a 64 x 64 grid one row per item (one row a cycle, top row first). The
// last row starts the passes (or, with zero generations, the emission); each
// generation streams the grid through the single read port of one bank and
// writes the other bank, with eight lanes of eight cells computing a whole row
// per cycle. Then the final grid is emitted one row a cycle while the output
// is taken. Rows are accepted only while loading; the next grid may load while
// the last result waits. Registers are read live and are to be written only
// while the block is idle.
module cave_cellular_automaton_top import cca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cca_row_if.sink   row_in,
  cca_res_if.source res_out,
  cca_cfg_if.sink   cfg
);

  cca_cfg_t cfg_regs;

  assign cfg.ready = 1'b1;

  // Write the addressed register, drop writes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.birth_limit <= BIRTH_RST;
      cfg_regs.death_limit <= DEATH_RST;
      cfg_regs.generations <= GENS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_BIRTH: cfg_regs.birth_limit <= cfg.wdata;
        REG_DEATH: cfg_regs.death_limit <= cfg.wdata;
        REG_GENS:  cfg_regs.generations <= cfg.wdata;
        default: begin
        end
      endcase
    end
  end

  cca_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .row_in   (row_in),
    .res_out  (res_out)
  );

endmodule
